/* src/aftf_pkg.sv */
// shared types and constants for the api frame transmit framer
// no dependencies; imported by every module of the framer
package aftf_pkg;

    localparam logic [7:0] DELIM_BYTE = 8'h7E;
    localparam logic [7:0] CSUM_BASE  = 8'hFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // position of a result within the expansion of one command
    typedef logic [2:0] step_t;
    localparam step_t STEP_DELIM  = 3'd0;
    localparam step_t STEP_LEN_HI = 3'd1;
    localparam step_t STEP_LEN_LO = 3'd2;
    localparam step_t STEP_DATA   = 3'd3;
    localparam step_t STEP_CSUM   = 3'd4;

    // one classified input item, as handed from front to back
    typedef struct packed {
        logic        hdr;
        logic [15:0] len;
        logic [7:0]  data;
        logic        csum_en;
        logic [7:0]  csum;
    } cmd_t;

endpackage

/* src/api_frame_transmit_framer_core.sv */
// top level of the api frame transmit framer
// depends on aftf_pkg, aftf_front, aftf_queue, aftf_back
//
//  channel  | handshake        | fields
//  ---------+------------------+--------------------------------------
//  input    | push / full      | payload_byte, frame_length
//  result   | empty / pop      | out_byte, is_checksum, run_last
//
// a payload byte inside a frame yields one result, at one result per cycle while pop is held and the queue is not empty
// the first byte of a frame yields four results (five for a one-byte frame), the last byte two;
// each byte passes through the output stage, which sets the rate
// a four-entry command queue lets input run ahead while results stall
// reset clears frame state, queue pointers and the output stage
module api_frame_transmit_framer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  payload_byte,
    input  logic [15:0] frame_length,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        is_checksum,
    output logic        run_last
);
    import aftf_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    cmd_t wr_cmd;
    cmd_t rd_cmd;

    aftf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (wr_cmd)
    );

    aftf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (wr_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (rd_cmd),
        .q_empty (q_empty)
    );

    aftf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (rd_cmd),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .is_checksum (is_checksum),
        .run_last    (run_last)
    );

endmodule

/* src/aftf_front.sv */
// front end: accepts input bytes, tracks frame state and builds commands
// depends on aftf_pkg
module aftf_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [7:0]     payload_byte,
    input  logic [15:0]    frame_length,
    input  logic           q_full,
    output logic           q_push,
    output aftf_pkg::cmd_t q_cmd
);
    import aftf_pkg::*;

    logic        in_frame_reg, in_frame_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  sum_reg, sum_next;

    logic        first;
    logic        accept;
    logic        drop;
    logic [15:0] left_cur;
    logic [15:0] left_dec;
    logic [7:0]  sum_add;
    logic        last;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign first    = !in_frame_reg;
    // a first byte with zero length is taken and thrown away
    assign drop     = first && (frame_length == 16'd0);
    assign left_cur = first ? frame_length : left_reg;
    assign left_dec = left_cur - 16'd1;
    assign sum_add  = (first ? 8'd0 : sum_reg) + payload_byte;
    assign last     = (left_dec == 16'd0);

    assign q_push       = accept && !drop;
    assign q_cmd.hdr     = first;
    assign q_cmd.len     = frame_length;
    assign q_cmd.data    = payload_byte;
    assign q_cmd.csum_en = last;
    assign q_cmd.csum    = CSUM_BASE - sum_add;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        left_next     = left_reg;
        sum_next      = sum_reg;
        if (q_push)
        begin
            in_frame_next = !last;
            left_next     = left_dec;
            sum_next      = last ? 8'd0 : sum_add;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            left_reg     <= 16'd0;
            sum_reg      <= 8'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            left_reg     <= left_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

/* src/aftf_queue.sv */
// short command queue between front and back of the framer
// depends on aftf_pkg
module aftf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  aftf_pkg::cmd_t wr_cmd,
    output logic           q_full,
    input  logic           rd_en,
    output aftf_pkg::cmd_t rd_cmd,
    output logic           q_empty
);
    import aftf_pkg::*;

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wp_reg, wp_next;
    logic [QUEUE_AW-1:0] rp_reg, rp_next;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                do_wr, do_rd;

    assign q_full  = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_wr ? wp_reg + QUEUE_AW'(1) : wp_reg;
        rp_next  = do_rd ? rp_reg + QUEUE_AW'(1) : rp_reg;
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + (QUEUE_AW+1)'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - (QUEUE_AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wp_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/aftf_back.sv */
// back end: expands each command into header, payload and checksum bytes
// depends on aftf_pkg
module aftf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  aftf_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     out_byte,
    output logic           is_checksum,
    output logic           run_last
);
    import aftf_pkg::*;

    cmd_t  cmd_reg, cmd_next;
    logic  valid_reg, valid_next;
    step_t step_reg, step_next;
    step_t last_step;
    logic  at_last;
    logic  take;

    assign last_step   = cmd_reg.csum_en ? STEP_CSUM : STEP_DATA;
    assign at_last     = (step_reg == last_step);
    assign empty       = !valid_reg;
    assign is_checksum = (step_reg == STEP_CSUM);
    assign run_last    = at_last;

    // load the next command when idle or when the last byte is transferred
    assign take  = (!valid_reg || (pop && at_last)) && !q_empty;
    assign q_pop = take;

    always_comb
    begin
        unique case (step_reg)
            STEP_DELIM:  out_byte = DELIM_BYTE;
            STEP_LEN_HI: out_byte = cmd_reg.len[15:8];
            STEP_LEN_LO: out_byte = cmd_reg.len[7:0];
            STEP_DATA:   out_byte = cmd_reg.data;
            STEP_CSUM:   out_byte = cmd_reg.csum;
            default:     out_byte = cmd_reg.data;
        endcase
    end

    always_comb
    begin
        cmd_next   = cmd_reg;
        valid_next = valid_reg;
        step_next  = step_reg;
        if (take)
        begin
            cmd_next   = q_cmd;
            valid_next = 1'b1;
            step_next  = q_cmd.hdr ? STEP_DELIM : STEP_DATA;
        end
        else if (valid_reg && pop)
        begin
            if (at_last)
                valid_next = 1'b0;
            else
                step_next = step_reg + step_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= STEP_DATA;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* sim/tb_api_frame_transmit_framer_core.sv */
// self-checking testbench for api_frame_transmit_framer_core
// predicts every framed byte in-line and checks results as they pop out
// depends on aftf_pkg and the framer rtl only
module tb_api_frame_transmit_framer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import aftf_pkg::DELIM_BYTE;
    import aftf_pkg::CSUM_BASE;

    typedef struct packed {
        logic [7:0] data;
        logic       csum;
        logic       last;
    } tx_byte_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        is_checksum;
    logic        run_last;

    // framing state of the predictor
    logic        frame_open;
    logic [15:0] frame_left;
    logic [7:0]  frame_sum;

    tx_byte_t    tx_expected[$];

    int errors;
    int framed_items;
    int ignored_items;
    int frames_closed;
    int results_seen;
    int full_stall_cycles;
    int burst_left;
    int sink_hold;
    int sink_stall;
    int sink_run;
    bit fast_mode;

    api_frame_transmit_framer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .is_checksum  (is_checksum),
        .run_last     (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void queue_tx(input logic [7:0] data, input logic csum);
        tx_byte_t t;
        t.data = data;
        t.csum = csum;
        t.last = 1'b0;
        tx_expected.push_back(t);
    endfunction

    // expected bytes for one accepted input transfer
    function automatic void encode_byte(input logic [7:0] b, input logic [15:0] len);
        if (!frame_open)
        begin
            if (len == 16'd0)
            begin
                ignored_items++;
                return;
            end
            queue_tx(DELIM_BYTE, 1'b0);
            queue_tx(len[15:8], 1'b0);
            queue_tx(len[7:0], 1'b0);
            frame_sum  = 8'd0;
            frame_left = len;
            frame_open = 1'b1;
        end
        framed_items++;
        queue_tx(b, 1'b0);
        frame_sum  = frame_sum + b;
        frame_left = frame_left - 16'd1;
        if (frame_left == 16'd0)
        begin
            queue_tx(CSUM_BASE - frame_sum, 1'b1);
            frame_open = 1'b0;
            frame_sum  = 8'd0;
            frames_closed++;
        end
        tx_expected[tx_expected.size() - 1].last = 1'b1;
    endfunction

    // one input transfer, with random bursts and gaps unless in fast mode
    task automatic send_byte(input logic [7:0] b, input logic [15:0] len);
        int gap;
        if (!fast_mode)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 10);
                if (gap > 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        push         <= 1'b1;
        payload_byte <= b;
        frame_length <= len;
        do @(posedge clk); while (full);
        encode_byte(b, len);
    endtask

    // length only matters on the first byte of a frame
    task automatic send_random_byte(input int max_len, input bit allow_noise);
        logic [15:0] len;
        len = 16'($urandom_range(0, 65535));
        if (!frame_open)
        begin
            if (allow_noise && $urandom_range(0, 9) == 0)
                len = 16'd0;
            else if ($urandom_range(0, 4) == 0)
                len = 16'($urandom_range(1, max_len));
            else
                len = 16'($urandom_range(1, 6));
        end
        send_byte(8'($urandom_range(0, 255)), len);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (tx_expected.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic test_directed();
        // single-byte frames: header, byte and checksum from one transfer
        send_byte(8'h00, 16'd1);
        send_byte(8'hFF, 16'd1);
        // zero length outside a frame is dropped
        send_byte(8'hAA, 16'd0);
        send_byte(8'h7E, 16'd1);
        // length changes inside a frame are ignored
        send_byte(8'h12, 16'd3);
        send_byte(8'h34, 16'd0);
        send_byte(8'h56, 16'hFFFF);
        // checksum sum wraps
        send_byte(8'hFF, 16'd2);
        send_byte(8'hFF, 16'hABCD);
        send_byte(8'h01, 16'd2);
        send_byte(8'h80, 16'h7FFF);
    endtask

    // sink holds off while the sender keeps offering, then sender drains
    task automatic test_backpressure();
        sink_hold = 100;
        repeat (20) send_random_byte(8, 1'b1);
        while (frame_open) send_random_byte(8, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int start;
        start = framed_items;
        while (framed_items - start < 50) send_random_byte(16, 1'b1);
        while (frame_open) send_random_byte(16, 1'b0);
    endtask

    // maximum frame length opened and streamed back to back, left open
    task automatic test_longest_frame();
        logic [7:0] b;
        fast_mode = 1'b1;
        b = 8'($urandom_range(0, 255));
        send_byte(b, 16'hFFFF);
        repeat (15)
        begin
            b = 8'($urandom_range(0, 255));
            send_byte(b, 16'($urandom_range(0, 65535)));
        end
        wait_drained();
        fast_mode = 1'b0;
    endtask

    initial
    begin
        push         <= 1'b0;
        payload_byte <= 8'h00;
        frame_length <= 16'h0000;
        rst_n        <= 1'b0;
        frame_open = 1'b0;
        frame_left = 16'd0;
        frame_sum  = 8'd0;
        errors = 0;
        framed_items = 0;
        ignored_items = 0;
        frames_closed = 0;
        burst_left = 0;
        sink_hold = 0;
        fast_mode = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_frames();
        test_longest_frame();
        wait_drained();

        $display("framed %0d input bytes into %0d frames, %0d zero-length bytes dropped",
                 framed_items, frames_closed, ignored_items);
        $display("checked %0d output bytes, input held off by full for %0d cycles",
                 results_seen, full_stall_cycles);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result sink: random runs and stalls, plus requested long hold-off
    initial
    begin
        pop <= 1'b0;
        sink_stall = 0;
        sink_run = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                pop <= 1'b0;
                sink_hold--;
            end
            else if (sink_stall > 0)
            begin
                pop <= 1'b0;
                sink_stall--;
            end
            else
            begin
                pop <= 1'b1;
                if (sink_run > 0)
                    sink_run--;
                else
                begin
                    sink_run = $urandom_range(1, 12);
                    if (fast_mode)
                        sink_stall = 0;
                    else if ($urandom_range(0, 3) == 0)
                        sink_stall = $urandom_range(3, 8);
                    else
                        sink_stall = $urandom_range(0, 2);
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        tx_byte_t want;
        if (rst_n && push && full)
            full_stall_cycles++;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (tx_expected.size() == 0)
            begin
                errors++;
                if (errors < 30)
                    $display("%0t: unexpected transfer out_byte=%h is_checksum=%b run_last=%b",
                             $time, out_byte, is_checksum, run_last);
            end
            else
            begin
                want = tx_expected.pop_front();
                if (out_byte !== want.data || is_checksum !== want.csum
                    || run_last !== want.last)
                begin
                    errors++;
                    if (errors < 30)
                    begin
                        if (out_byte !== want.data)
                            $display("%0t: out_byte expected %h got %h",
                                     $time, want.data, out_byte);
                        if (is_checksum !== want.csum)
                            $display("%0t: is_checksum expected %b got %b",
                                     $time, want.csum, is_checksum);
                        if (run_last !== want.last)
                            $display("%0t: run_last expected %b got %b",
                                     $time, want.last, run_last);
                    end
                end
            end
        end
    end

endmodule
